[src/dhfk_pkg.sv]
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types and constants of the modified DH forward kinematics chain.
// ----------------------------------------------------------------------------
package dhfk_pkg;

  localparam int DATA_BITS    = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int ROT_FRAC     = DATA_BITS - 2;
  localparam int MUL_W        = 2 * DATA_BITS - ROT_FRAC + 1;
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;
  localparam int NUM_ROWS     = 3;
  localparam int LAST_ROW     = NUM_ROWS - 1;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1,         32'sd1,         32'sd0
  };

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_JOINT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                          cmd;
    logic [1:0]                    row_select;
    logic signed [DATA_BITS-1:0]   base_col0;
    logic signed [DATA_BITS-1:0]   base_col1;
    logic signed [DATA_BITS-1:0]   base_col2;
    logic signed [DATA_BITS-1:0]   base_trans;
    logic signed [ANGLE_BITS-1:0]  alpha_angle;
    logic signed [DATA_BITS-1:0]   link_length;
    logic signed [ANGLE_BITS-1:0]  theta_angle;
    logic signed [DATA_BITS-1:0]   link_offset;
    logic                          first_joint;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                    row_index;
    logic signed [DATA_BITS-1:0]   rot_col0;
    logic signed [DATA_BITS-1:0]   rot_col1;
    logic signed [DATA_BITS-1:0]   rot_col2;
    logic signed [DATA_BITS-1:0]   trans_out;
    logic                          last_row;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } job_t;

endpackage

[src/dhfk_front.sv]
// ----------------------------------------------------------------------------
// dhfk_front
// Input side: accepts items, drops loads to a nonexistent row, queues the rest.
// ----------------------------------------------------------------------------
module dhfk_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dhfk_pkg::in_item_t in_item_i,
  output dhfk_pkg::job_t     job_o,
  input  logic               job_pop_i
);
  import dhfk_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  in_item_t        fifo_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, keep, take;

  assign full   = (cnt_q == CntW'(Depth));
  assign accept = push & ~full;
  // a load to row three has no effect at all
  assign keep   = accept & ((in_item_i.cmd == CMD_JOINT) ||
                            (in_item_i.row_select < 2'(NUM_ROWS)));
  assign take   = job_pop_i & (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (keep && !take) cnt_d = cnt_q + 1'b1;
    else if (!keep && take) cnt_d = cnt_q - 1'b1;
  end

  assign job_o.valid = (cnt_q != '0);
  assign job_o.item  = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (keep) wr_q <= wr_q + 1'b1;
      if (take) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) fifo_q[wr_q] <= in_item_i;
  end

endmodule

[src/dhfk_cordic.sv]
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative sine/cosine, one rotation step per cycle.
// ----------------------------------------------------------------------------
module dhfk_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [dhfk_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                                   done_o,
  output logic signed [dhfk_pkg::DATA_BITS-1:0]  cos_o,
  output logic signed [dhfk_pkg::DATA_BITS-1:0]  sin_o
);
  import dhfk_pkg::*;

  localparam int UpSh = (ROT_FRAC >= 30) ? ROT_FRAC - 30 : 0;
  localparam int DnSh = (ROT_FRAC < 30) ? 30 - ROT_FRAC : 0;
  localparam logic signed [63:0] Rnd  = (DnSh > 0) ? (64'sd1 <<< ((DnSh > 0) ? DnSh - 1 : 0))
                                                   : 64'sd0;
  localparam logic signed [63:0] RMax = (64'sd1 <<< (DATA_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] RMin = -RMax - 64'sd1;

  logic signed [CORDIC_W-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [CORDIC_W-1:0] x_sh, y_sh, atan, z_init, x_f, y_f;
  logic [STEP_BITS-1:0]       i_q;
  logic                       busy_q, done_q, flip_q, flip;
  logic [31:0]                z32;

  function automatic logic signed [DATA_BITS-1:0] to_rot(input logic signed [CORDIC_W-1:0] v);
    logic signed [63:0] w;
    w = {{(64-CORDIC_W){v[CORDIC_W-1]}}, v};
    w = ((w <<< UpSh) + Rnd) >>> DnSh;
    if (w > RMax) w = RMax;
    else if (w < RMin) w = RMin;
    return w[DATA_BITS-1:0];
  endfunction

  always_comb begin
    z32    = {angle_i, {(32-ANGLE_BITS){1'b0}}};
    // second and third quadrant: turn by pi, negate at the end
    flip   = z32[31] ^ z32[30];
    z_init = {{(CORDIC_W-31){z32[31] ^ flip}}, z32[30:0]};
    x_sh   = x_q >>> i_q;
    y_sh   = y_q >>> i_q;
    atan   = {{(CORDIC_W-32){ATAN_TAB[i_q][31]}}, ATAN_TAB[i_q]};
    if (!z_q[CORDIC_W-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan;
    end
    x_f = flip_q ? -x_q : x_q;
    y_f = flip_q ? -y_q : y_q;
  end

  assign done_o = done_q;
  assign cos_o  = to_rot(x_f);
  assign sin_o  = to_rot(y_f);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

endmodule

[src/dhfk_mul.sv]
// ----------------------------------------------------------------------------
// dhfk_mul
// Two-stage rounding multiplier: exact product, then shift with rounding
// half away from zero.
// ----------------------------------------------------------------------------
module dhfk_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  go_i,
  input  logic signed [dhfk_pkg::DATA_BITS-1:0] a_i,
  input  logic signed [dhfk_pkg::DATA_BITS-1:0] b_i,
  output logic                                  done_o,
  output logic signed [dhfk_pkg::MUL_W-1:0]     res_o
);
  import dhfk_pkg::*;

  localparam int PW = 2 * DATA_BITS;
  localparam logic [PW-1:0] Rnd = PW'(1) << (ROT_FRAC - 1);

  logic [DATA_BITS-1:0] ma, mb;
  logic [PW-1:0]        prod_q, prod_r;
  logic                 neg_q, v1_q, done_q;
  logic [MUL_W-2:0]     mag;
  logic signed [MUL_W-1:0] res_q;

  assign ma     = a_i[DATA_BITS-1] ? -a_i : a_i;
  assign mb     = b_i[DATA_BITS-1] ? -b_i : b_i;
  assign prod_r = prod_q + Rnd;
  assign mag    = prod_r[PW-1:ROT_FRAC];

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= go_i;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      prod_q <= PW'(ma) * PW'(mb);
      neg_q  <= a_i[DATA_BITS-1] ^ b_i[DATA_BITS-1];
    end
    if (v1_q) res_q <= neg_q ? -{1'b0, mag} : {1'b0, mag};
  end

endmodule

[src/dhfk_back.sv]
// ----------------------------------------------------------------------------
// dhfk_back
// Execution side: joint transform, chain product and base product on one
// shared multiplier, with a small result queue.
// ----------------------------------------------------------------------------
module dhfk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhfk_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                empty,
  input  logic                pop,
  output dhfk_pkg::out_item_t out_item_o
);
  import dhfk_pkg::*;

  localparam int AW       = DATA_BITS + 5;
  localparam int OqDepth  = 4;
  localparam int OqPtrW   = $clog2(OqDepth);
  localparam int OqCntW   = $clog2(OqDepth + 1);
  localparam logic [2:0] JtLast   = 3'd5;
  localparam logic [1:0] TransCol = 2'd3;
  localparam logic [1:0] KLast    = 2'(LAST_ROW);
  localparam logic signed [AW-1:0] SMax = {{(AW-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] SMin = ~SMax;
  localparam logic signed [DATA_BITS-1:0] One = DATA_BITS'(1) <<< ROT_FRAC;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TRIG = 6'b000010,
    S_JT   = 6'b000100,
    S_MAT  = 6'b001000,
    S_COPY = 6'b010000,
    S_ROW  = 6'b100000
  } state_e;

  state_e state_q;
  logic [2:0] j_q;
  logic [1:0] r_q, c_q, k_q;
  logic       go_q, out_ph_q, first_q;

  logic signed [DATA_BITS-1:0] cr_q [9];
  logic signed [DATA_BITS-1:0] ctr_q [3];
  logic signed [DATA_BITS-1:0] br_q [9];
  logic signed [DATA_BITS-1:0] btr_q [3];
  logic signed [DATA_BITS-1:0] rr_q [9];
  logic signed [DATA_BITS-1:0] pp_q [3];
  logic signed [DATA_BITS-1:0] nr_q [9];
  logic signed [DATA_BITS-1:0] np_q [3];
  logic signed [DATA_BITS-1:0] orow_q [4];
  logic signed [DATA_BITS-1:0] ca_q, sa_q, ct_q, st_q, len_q, off_q;
  logic signed [AW-1:0]        acc_q, acc_d, acc_base, mres;

  logic signed [DATA_BITS-1:0] a_sel, b_sel, cr_rd, ctr_rd, init_val, jt_val;
  logic [3:0]                  idx_a, idx_b, cr_addr, load_base;
  logic [1:0]                  ctr_addr;

  logic                        cs_start, ca_done, ct_done;
  logic signed [DATA_BITS-1:0] cos_a, sin_a, cos_t, sin_t;
  logic                        mul_done;
  logic signed [MUL_W-1:0]     mul_res;

  out_item_t         oq_q [OqDepth];
  logic [OqPtrW-1:0] oq_wr_q, oq_rd_q;
  logic [OqCntW-1:0] oq_cnt_q;
  logic              oq_full, oq_push, oq_take;

  function automatic logic signed [DATA_BITS-1:0] sat_acc(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] w;
    w = v;
    if (w > SMax) w = SMax;
    else if (w < SMin) w = SMin;
    return w[DATA_BITS-1:0];
  endfunction

  assign job_pop_o = (state_q == S_IDLE) & job_i.valid;
  assign cs_start  = job_pop_o & (job_i.item.cmd == CMD_JOINT);

  dhfk_cordic u_cordic_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (job_i.item.alpha_angle),
    .done_o  (ca_done),
    .cos_o   (cos_a),
    .sin_o   (sin_a)
  );

  dhfk_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (job_i.item.theta_angle),
    .done_o  (ct_done),
    .cos_o   (cos_t),
    .sin_o   (sin_t)
  );

  dhfk_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .a_i    (a_sel),
    .b_i    (b_sel),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // operand selection, one read address per register file
  always_comb begin
    idx_a     = {2'b00, r_q} * 4'd3 + {2'b00, k_q};
    idx_b     = {2'b00, k_q} * 4'd3 + {2'b00, (c_q == TransCol) ? 2'b00 : c_q};
    load_base = {2'b00, job_i.item.row_select} * 4'd3;
    cr_addr   = out_ph_q ? idx_b : idx_a;
    ctr_addr  = out_ph_q ? k_q : r_q;
    cr_rd     = cr_q[cr_addr];
    ctr_rd    = ctr_q[ctr_addr];
    a_sel     = out_ph_q ? br_q[idx_a] : cr_rd;
    if (c_q == TransCol) b_sel = out_ph_q ? ctr_rd : pp_q[k_q];
    else                 b_sel = out_ph_q ? cr_rd : rr_q[idx_b];
    init_val  = (c_q == TransCol) ? (out_ph_q ? btr_q[r_q] : ctr_rd) : '0;
    if (state_q == S_JT) begin
      unique case (j_q)
        3'd0: begin a_sel = ca_q; b_sel = st_q; end
        3'd1: begin a_sel = ca_q; b_sel = ct_q; end
        3'd2: begin a_sel = sa_q; b_sel = st_q; end
        3'd3: begin a_sel = sa_q; b_sel = ct_q; end
        3'd4: begin a_sel = sa_q; b_sel = off_q; end
        3'd5: begin a_sel = ca_q; b_sel = off_q; end
        default: begin a_sel = ca_q; b_sel = st_q; end
      endcase
    end
    mres     = {{(AW-MUL_W){mul_res[MUL_W-1]}}, mul_res};
    acc_base = (k_q == 2'd0) ? {{(AW-DATA_BITS){init_val[DATA_BITS-1]}}, init_val} : acc_q;
    acc_d    = acc_base + mres;
    // the y offset of the joint carries a minus sign
    jt_val   = sat_acc((j_q == 3'd4) ? -mres : mres);
  end

  assign oq_full    = (oq_cnt_q == OqCntW'(OqDepth));
  assign oq_push    = (state_q == S_ROW) & ~oq_full;
  assign oq_take    = pop & ~empty;
  assign empty      = (oq_cnt_q == '0);
  assign out_item_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      j_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      go_q     <= 1'b0;
      out_ph_q <= 1'b0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
      for (int i = 0; i < 9; i++) begin
        cr_q[i] <= (i % 4 == 0) ? One : '0;
        br_q[i] <= (i % 4 == 0) ? One : '0;
      end
      for (int i = 0; i < 3; i++) begin
        ctr_q[i] <= '0;
        btr_q[i] <= '0;
      end
    end else begin
      go_q <= 1'b0;
      if (oq_push) oq_wr_q <= oq_wr_q + 1'b1;
      if (oq_take) oq_rd_q <= oq_rd_q + 1'b1;
      if (oq_push && !oq_take) oq_cnt_q <= oq_cnt_q + 1'b1;
      else if (!oq_push && oq_take) oq_cnt_q <= oq_cnt_q - 1'b1;

      unique case (state_q)
        S_IDLE: begin
          if (job_pop_o) begin
            if (job_i.item.cmd == CMD_LOAD) begin
              br_q[load_base]        <= job_i.item.base_col0;
              br_q[load_base + 4'd1] <= job_i.item.base_col1;
              br_q[load_base + 4'd2] <= job_i.item.base_col2;
              btr_q[job_i.item.row_select] <= job_i.item.base_trans;
            end else begin
              state_q <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          if (ca_done && ct_done) begin
            j_q     <= '0;
            go_q    <= 1'b1;
            state_q <= S_JT;
          end
        end
        S_JT: begin
          if (mul_done) begin
            if (j_q == JtLast) begin
              r_q <= '0;
              c_q <= '0;
              k_q <= '0;
              if (first_q) begin
                state_q <= S_COPY;
              end else begin
                out_ph_q <= 1'b0;
                go_q     <= 1'b1;
                state_q  <= S_MAT;
              end
            end else begin
              j_q  <= j_q + 1'b1;
              go_q <= 1'b1;
            end
          end
        end
        S_MAT: begin
          if (mul_done) begin
            if (k_q != KLast) begin
              k_q  <= k_q + 1'b1;
              go_q <= 1'b1;
            end else begin
              k_q <= '0;
              if (c_q == TransCol) begin
                c_q <= '0;
                if (out_ph_q) begin
                  state_q <= S_ROW;
                end else if (r_q == 2'(LAST_ROW)) begin
                  r_q     <= '0;
                  state_q <= S_COPY;
                end else begin
                  r_q  <= r_q + 1'b1;
                  go_q <= 1'b1;
                end
              end else begin
                c_q  <= c_q + 1'b1;
                go_q <= 1'b1;
              end
            end
          end
        end
        S_COPY: begin
          // restart takes the joint transform, otherwise the new product
          for (int i = 0; i < 9; i++) cr_q[i] <= first_q ? rr_q[i] : nr_q[i];
          for (int i = 0; i < 3; i++) ctr_q[i] <= first_q ? pp_q[i] : np_q[i];
          out_ph_q <= 1'b1;
          go_q     <= 1'b1;
          state_q  <= S_MAT;
        end
        S_ROW: begin
          if (!oq_full) begin
            if (r_q == 2'(LAST_ROW)) begin
              r_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              r_q     <= r_q + 1'b1;
              go_q    <= 1'b1;
              state_q <= S_MAT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_start) begin
      len_q   <= job_i.item.link_length;
      off_q   <= job_i.item.link_offset;
      first_q <= job_i.item.first_joint;
    end
    if (state_q == S_TRIG && ca_done && ct_done) begin
      ca_q     <= cos_a;
      sa_q     <= sin_a;
      ct_q     <= cos_t;
      st_q     <= sin_t;
      rr_q[0]  <= cos_t;
      rr_q[1]  <= -sin_t;
      rr_q[2]  <= '0;
      rr_q[5]  <= -sin_a;
      rr_q[8]  <= cos_a;
      pp_q[0]  <= len_q;
    end
    if (state_q == S_JT && mul_done) begin
      case (j_q)
        3'd0:    rr_q[3] <= jt_val;
        3'd1:    rr_q[4] <= jt_val;
        3'd2:    rr_q[6] <= jt_val;
        3'd3:    rr_q[7] <= jt_val;
        3'd4:    pp_q[1] <= jt_val;
        default: pp_q[2] <= jt_val;
      endcase
    end
    if (state_q == S_MAT && mul_done) begin
      acc_q <= acc_d;
      if (k_q == KLast) begin
        if (out_ph_q) orow_q[c_q] <= sat_acc(acc_d);
        else if (c_q == TransCol) np_q[r_q] <= sat_acc(acc_d);
        else nr_q[idx_a - {2'b00, k_q} + {2'b00, c_q}] <= sat_acc(acc_d);
      end
    end
    if (oq_push) begin
      oq_q[oq_wr_q].row_index <= r_q;
      oq_q[oq_wr_q].rot_col0  <= orow_q[0];
      oq_q[oq_wr_q].rot_col1  <= orow_q[1];
      oq_q[oq_wr_q].rot_col2  <= orow_q[2];
      oq_q[oq_wr_q].trans_out <= orow_q[3];
      oq_q[oq_wr_q].last_row  <= (r_q == 2'(LAST_ROW));
    end
  end

endmodule

[src/dh_forward_kinematics_chain.sv]
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Forward kinematics over a modified DH joint chain in fixed point.
//
//   channel  handshake        payload      transaction
//   input    push / full      in_item_i    base row load or joint step
//   result   empty / pop      out_item_o   one row of the absolute pose
//
// A load is written in the back end as it is popped. A joint step is one pop,
// 32 CORDIC steps and one hand-off, then 78 products (42 with first_joint) on
// the single shared multiplier, one copy step and one output step per result
// row. Reset is asynchronous; all poses reset to identity. Each side stalls
// on its own: a two-entry input queue and a four-entry result queue.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  dhfk_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output dhfk_pkg::out_item_t out_item_o
);
  import dhfk_pkg::*;

  job_t job;
  logic job_pop;

  dhfk_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .job_o     (job),
    .job_pop_i (job_pop)
  );

  dhfk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

[src/dhfk_checker.sv]
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level checks of the result stream of the kinematics chain.
// ----------------------------------------------------------------------------
module dhfk_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input dhfk_pkg::out_item_t out_item_o
);
  import dhfk_pkg::*;

  // a waiting row holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result row changed while waiting");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_row == (out_item_o.row_index == 2'(LAST_ROW))))
    else $error("last_row does not match row_index");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.row_index < 2'(NUM_ROWS)))
    else $error("row_index out of range");

  // rows of one joint come out in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_item_o.last_row) |=>
      (empty || (out_item_o.row_index == $past(out_item_o.row_index) + 2'd1)))
    else $error("result rows out of order");

endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (.*);

[tb/dh_forward_kinematics_chain_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_test
// Self-checking bench for the modified DH forward kinematics chain. A short
// table of directed items (angle and length extremes, a bad row select,
// restarts, zeroed base rotations) is followed by random loads and joint
// steps. Every result row is compared with a local fixed-point model of the
// chain. Both sides idle in bursts, and the result side holds off for a long
// stretch once so that the input side backs up.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_test;
  import dhfk_pkg::*;

  localparam int  RANDOM_ITEMS = 130;
  localparam int  CALM_FROM    = 100;
  localparam int  MAX_CYCLES   = 1000000;
  localparam int  DRAIN_CYCLES = 400;
  localparam int  HOLD_CYCLES  = 2000;
  localparam longint ONE_ROT   = 64'sd1 <<< ROT_FRAC;
  localparam logic signed [31:0] BASE_TR0 = 32'sh7fffffff;
  localparam logic signed [31:0] BASE_TR1 = 32'sh80000000;
  localparam logic signed [31:0] BASE_TR2 = 32'sh30390000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item_o;

  dh_forward_kinematics_chain DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .in_item_i(in_item_i), .empty(empty), .pop(pop), .out_item_o(out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // pose model state
  longint    chain_rot [9];
  longint    chain_tr [3];
  longint    base_rot [9];
  longint    base_tr [3];
  out_item_t pose_rows_q [$];

  int  errors = 0;
  int  cycles = 0;
  int  rows_seen = 0;
  int  joints_sent = 0;
  int  loads_sent = 0;
  bit  calm = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product rescaled to rotation format, rounded half away from zero
  function automatic longint rmul(longint a, longint b);
    longint ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m = (ua * ub + (64'sd1 <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  task automatic cordic_sin_cos(input logic [ANGLE_BITS-1:0] ang, output longint c,
                                output longint s);
    logic [31:0] z32;
    bit          flip;
    longint      x, y, z, nx;
    z32 = {ang, {(32 - ANGLE_BITS){1'b0}}};
    flip = (z32[31:30] == 2'd1) || (z32[31:30] == 2'd2);
    if (flip) z32 = z32 + 32'h80000000;
    z = longint'($signed(z32));
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = sat32(x);
    s = sat32(y);
  endtask

  task automatic reset_pose();
    for (int i = 0; i < 9; i++) begin
      chain_rot[i] = (i % 4 == 0) ? ONE_ROT : 0;
      base_rot[i] = chain_rot[i];
    end
    for (int i = 0; i < 3; i++) begin
      chain_tr[i] = 0;
      base_tr[i] = 0;
    end
  endtask

  // advance the model by one accepted transaction and queue its pose rows
  task automatic predict_pose(input in_item_t it, input bit typed);
    longint    ca, sa, ct, st, d, acc, sum;
    longint    jr [9];
    longint    jp [3];
    longint    nr [9];
    longint    np [3];
    out_item_t row;
    if (it.cmd == CMD_LOAD) begin
      if (it.row_select == 2'd3) return;
      base_rot[it.row_select * 3 + 0] = longint'(it.base_col0);
      base_rot[it.row_select * 3 + 1] = longint'(it.base_col1);
      base_rot[it.row_select * 3 + 2] = longint'(it.base_col2);
      base_tr[it.row_select] = longint'(it.base_trans);
      return;
    end
    cordic_sin_cos(it.alpha_angle, ca, sa);
    cordic_sin_cos(it.theta_angle, ct, st);
    d = longint'(it.link_offset);
    jr = '{ct, -st, 0, sat32(rmul(ca, st)), sat32(rmul(ca, ct)), -sa,
           sat32(rmul(sa, st)), sat32(rmul(sa, ct)), ca};
    jp = '{longint'(it.link_length), sat32(-rmul(sa, d)), sat32(rmul(ca, d))};
    if (it.first_joint) begin
      chain_rot = jr;
      chain_tr = jp;
    end else begin
      for (int r = 0; r < 3; r++) begin
        acc = chain_tr[r];
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += rmul(chain_rot[r * 3 + k], jr[k * 3 + c]);
          nr[r * 3 + c] = sat32(sum);
        end
        for (int k = 0; k < 3; k++) acc += rmul(chain_rot[r * 3 + k], jp[k]);
        np[r] = sat32(acc);
      end
      chain_rot = nr;
      chain_tr = np;
    end
    for (int r = 0; r < 3; r++) begin
      longint rot [3];
      row.row_index = r[1:0];
      for (int c = 0; c < 3; c++) begin
        sum = 0;
        for (int k = 0; k < 3; k++) sum += rmul(base_rot[r * 3 + k], chain_rot[k * 3 + c]);
        rot[c] = sat32(sum);
      end
      acc = base_tr[r];
      for (int k = 0; k < 3; k++) acc += rmul(base_rot[r * 3 + k], chain_tr[k]);
      row.rot_col0 = rot[0][31:0];
      row.rot_col1 = rot[1][31:0];
      row.rot_col2 = rot[2][31:0];
      row.trans_out = 32'(sat32(acc));
      row.last_row = (r == LAST_ROW);
      if (typed) begin
        // zeroed base rotation: pose is just the base translation
        row.rot_col0 = '0;
        row.rot_col1 = '0;
        row.rot_col2 = '0;
        row.trans_out = (r == 0) ? BASE_TR0 : (r == 1) ? BASE_TR1 : BASE_TR2;
      end
      pose_rows_q = {pose_rows_q, row};
    end
  endtask

  function automatic in_item_t joint_item(logic [15:0] alpha, logic [31:0] len,
                                          logic [15:0] theta, logic [31:0] off, bit fj);
    in_item_t it;
    it = '0;
    it.cmd = CMD_JOINT;
    it.alpha_angle = alpha;
    it.link_length = len;
    it.theta_angle = theta;
    it.link_offset = off;
    it.first_joint = fj;
    return it;
  endfunction

  function automatic in_item_t load_item(logic [1:0] row, logic [31:0] c0, logic [31:0] c1,
                                         logic [31:0] c2, logic [31:0] tr);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.row_select = row;
    it.base_col0 = c0;
    it.base_col1 = c1;
    it.base_col2 = c2;
    it.base_trans = tr;
    return it;
  endfunction

  function automatic logic [31:0] rand_len();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff);
  endfunction

  function automatic logic [31:0] rand_rot();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    if ($urandom_range(0, 9) < 8) begin
      it = joint_item(16'($urandom()), rand_len(), 16'($urandom()), rand_len(),
                      $urandom_range(0, 4) == 0);
      it.row_select = 2'($urandom());
      it.base_col0 = $urandom();
      it.base_trans = $urandom();
    end else begin
      it = load_item(2'($urandom_range(0, 3)), rand_rot(), rand_rot(), rand_rot(),
                     rand_len());
      it.alpha_angle = 16'($urandom());
      it.link_offset = $urandom();
      it.first_joint = 1'($urandom());
    end
    return it;
  endfunction

  in_item_t stim_tab [$];
  bit       typed_tab [$];

  task automatic add_row(input in_item_t it, input bit typed);
    stim_tab = {stim_tab, it};
    typed_tab = {typed_tab, typed};
  endtask

  // offer one transaction and wait until it is taken
  task automatic send_item(input in_item_t it, input bit typed);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    predict_pose(it, typed);
    if (it.cmd == CMD_JOINT) joints_sent++;
    else loads_sent++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL dh_forward_kinematics_chain");
      $finish;
    end
  end

  // result side: check each transaction, idle in bursts, one long hold-off
  initial begin
    int        idle_left;
    int        hold_left;
    bit        held;
    out_item_t want;
    idle_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        rows_seen++;
        if (pose_rows_q.size() == 0) begin
          $error("unexpected result row %0d", out_item_o.row_index);
          errors++;
        end else begin
          want = pose_rows_q.pop_front();
          if (out_item_o.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, out_item_o.row_index);
            errors++;
          end
          if (out_item_o.rot_col0 !== want.rot_col0) begin
            $error("rot_col0: expected %0d, got %0d", want.rot_col0, out_item_o.rot_col0);
            errors++;
          end
          if (out_item_o.rot_col1 !== want.rot_col1) begin
            $error("rot_col1: expected %0d, got %0d", want.rot_col1, out_item_o.rot_col1);
            errors++;
          end
          if (out_item_o.rot_col2 !== want.rot_col2) begin
            $error("rot_col2: expected %0d, got %0d", want.rot_col2, out_item_o.rot_col2);
            errors++;
          end
          if (out_item_o.trans_out !== want.trans_out) begin
            $error("trans_out: expected %0d, got %0d", want.trans_out, out_item_o.trans_out);
            errors++;
          end
          if (out_item_o.last_row !== want.last_row) begin
            $error("last_row: expected %0d, got %0d", want.last_row, out_item_o.last_row);
            errors++;
          end
        end
      end
      if (!held && rows_seen >= 30) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int wait_cycles;
    reset_pose();
    // directed part
    add_row(joint_item(16'h0000, 32'h0, 16'h0000, 32'h0, 1'b0), 1'b0);
    add_row(joint_item(16'h7fff, 32'h7fffffff, 16'h8000, 32'h80000000, 1'b0), 1'b0);
    add_row(joint_item(16'h8000, 32'h80000000, 16'h7fff, 32'h7fffffff, 1'b1), 1'b0);
    add_row(joint_item(16'h4000, 32'h0, 16'hc000, 32'h00010000, 1'b0), 1'b0);
    add_row(joint_item(16'hc000, 32'h00020000, 16'h4000, 32'hffff0000, 1'b0), 1'b0);
    add_row(joint_item(16'h2000, 32'h00008000, 16'he000, 32'h00030000, 1'b0), 1'b0);
    // bad row select is dropped
    add_row(load_item(2'd3, '1, '1, '1, '1), 1'b0);
    add_row(load_item(2'd0, '0, '0, '0, BASE_TR0), 1'b0);
    add_row(load_item(2'd1, '0, '0, '0, BASE_TR1), 1'b0);
    add_row(load_item(2'd2, '0, '0, '0, BASE_TR2), 1'b0);
    add_row(joint_item(16'h1234, 32'h00050000, 16'hfedc, 32'h00070000, 1'b1), 1'b1);
    add_row(joint_item(16'h8000, 32'h7fffffff, 16'h8000, 32'h7fffffff, 1'b0), 1'b1);
    add_row(load_item(2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0);
    add_row(load_item(2'd1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000), 1'b0);
    add_row(load_item(2'd2, 32'h40000000, 32'hc0000000, 32'h40000000, 32'h0), 1'b0);
    add_row(joint_item(16'h7fff, 32'h7fffffff, 16'h7fff, 32'h7fffffff, 1'b1), 1'b0);
    add_row(joint_item(16'h8000, 32'h80000000, 16'h8000, 32'h80000000, 1'b0), 1'b0);
    add_row(load_item(2'd0, 32'h40000000, '0, '0, '0), 1'b0);
    add_row(load_item(2'd1, '0, 32'h40000000, '0, '0), 1'b0);
    add_row(load_item(2'd2, '0, '0, 32'h40000000, '0), 1'b0);
    add_row(joint_item(16'h0aaa, 32'h00010000, 16'h5555, 32'h00010000, 1'b1), 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[i]) send_item(stim_tab[i], typed_tab[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FROM) calm = 1'b1;
      send_item(rand_item(), 1'b0);
    end
    push <= 1'b0;

    wait_cycles = 0;
    while (pose_rows_q.size() != 0) begin
      @(posedge clk_i);
      wait_cycles++;
      if (wait_cycles > 20000) begin
        $display("result rows still missing: %0d", pose_rows_q.size());
        $display("FAIL dh_forward_kinematics_chain");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d joint steps and %0d base loads, %0d pose rows checked",
             joints_sent, loads_sent, rows_seen);
    $display("angle and length extremes, bad row select, restarts, long result stall");
    if (errors == 0 && pose_rows_q.size() == 0) begin
      $display("PASS dh_forward_kinematics_chain");
    end else begin
      $display("FAIL dh_forward_kinematics_chain");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dhfk_pkg.sv
src/dhfk_front.sv
src/dhfk_cordic.sv
src/dhfk_mul.sv
src/dhfk_back.sv
src/dh_forward_kinematics_chain.sv
src/dhfk_checker.sv
tb/dh_forward_kinematics_chain_test.sv
